FILE: rtl/wildcard_policy_classifier_table_macros.svh
// assertion macros for the policy classifier table
`ifndef WILDCARD_POLICY_CLASSIFIER_TABLE_MACROS_SVH
`define WILDCARD_POLICY_CLASSIFIER_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define WPCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WPCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WPCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WPCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/wpct_pkg.sv
// shared types and constants of the policy classifier table
`default_nettype none
package wpct_pkg;
	localparam int unsigned TableEntries = 64;
	localparam int unsigned EntryW = 32 + 32 + 16 + 8 + 64 + 3 + 32 + 32 + 16;

	typedef enum logic [2:0] {
		MODE_LOOKUP = 3'd0,
		MODE_APPEND = 3'd1,
		MODE_INSERT = 3'd2,
		MODE_REMOVE = 3'd3,
		MODE_UPDATE = 3'd4,
		MODE_CLEAR  = 3'd5,
		MODE_PURGE  = 3'd6,
		MODE_NONE   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SHIFT,
		FSM_WRITE,
		FSM_MOVE,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] port;
		logic [7:0]  proto;
		logic [63:0] expiry;
		logic [2:0]  act;
		logic [31:0] pkt;
		logic [31:0] byt;
		logic [15:0] prio;
	} entry_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [15:0] dst_port_num;
		logic [7:0]  proto_num;
		logic [63:0] expiry_time;
		logic [2:0]  entry_action;
		logic [31:0] packet_rate;
		logic [31:0] byte_rate;
		logic [15:0] entry_priority;
		logic [5:0]  entry_index;
		logic [63:0] current_time;
	} in_word_t;

	typedef struct packed {
		logic        matched;
		logic [2:0]  result_action;
		logic [31:0] result_packet_rate;
		logic [31:0] result_byte_rate;
		logic [1:0]  status;
		logic [6:0]  insert_position;
		logic [6:0]  purged_now;
		logic [6:0]  entry_total;
		logic [63:0] hit_total;
		logic [63:0] overflow_total;
		logic [63:0] purged_total;
	} out_word_t;

	function automatic logic entry_expired(entry_t e, logic [63:0] now);
		return (e.expiry != 64'd0) && (now > e.expiry);
	endfunction

	function automatic logic entry_hits(entry_t e, in_word_t w);
		logic ok;
		ok = (e.src == 32'd0 || e.src == w.src_address)
			&& (e.dst == 32'd0 || e.dst == w.dst_address)
			&& (e.port == 16'd0 || e.port == w.dst_port_num)
			&& (e.proto == 8'd0 || e.proto == w.proto_num);
		return ok && !entry_expired(e, w.current_time);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/wpct_ram.sv
// generic single-port write, single-port registered-read ram
`default_nettype none
module wpct_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(Depth)-1:0] wr_addr,
	input  wire logic [Width-1:0]         wr_data,
	input  wire logic [$clog2(Depth)-1:0] rd_addr,
	output logic      [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

FILE: rtl/wildcard_policy_classifier_table.sv
// policy classifier table: one entry ram walked by a sequencer, one word per operation
// lookup and purge walk the held entries in order; append writes at the end; clear
// empties the table; update reads the entry and writes new rates; remove moves the
// last entry into the hole; sorted insert scans, shifts the tail up and writes the entry
// the result is held in an output register; the next word is taken once it has left
// reset (arst_n low) clears count, counters and control; table contents stay undefined
`default_nettype none
`include "wildcard_policy_classifier_table_macros.svh"
module wildcard_policy_classifier_table
	import wpct_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TableEntries
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

	// control
	fsm_t           state_q, state_d;
	in_word_t       req_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  rd_i_q;   // read pointer
	logic [CW-1:0]  wr_i_q;   // write pointer (purge) / shift target
	logic [CW-1:0]  gone_q;
	logic           rd_pend_q;   // ram data valid this cycle
	logic [CW-1:0]  rd_at_q;     // index of the entry now on rd_data
	logic [63:0]    hit_q, ovf_q, purge_q;
	logic           out_valid_q;
	out_word_t      out_q;

	// ram port
	logic           ram_we;
	logic [AW-1:0]  ram_wa, ram_ra;
	entry_t         ram_wd, ram_rd;

	wpct_ram #(.Width(EntryW), .Depth(TABLE_ENTRIES)) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	entry_t new_e;
	assign new_e = '{src: req_q.src_address, dst: req_q.dst_address,
		port: req_q.dst_port_num, proto: req_q.proto_num, expiry: req_q.expiry_time,
		act: req_q.entry_action, pkt: req_q.packet_rate, byt: req_q.byte_rate,
		prio: req_q.entry_priority};

	logic [CW-1:0] idx_ext;
	assign idx_ext = CW'(req_q.entry_index);

	assign in_ready  = (state_q == FSM_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic accept;
	assign accept = in_valid && in_ready;

	// sequencer: scan issues one read per cycle and consumes it next cycle
	logic           issue;      // a read is issued this cycle
	logic [CW-1:0]  issue_at;
	logic           finish;     // result is final this cycle
	out_word_t      res;
	logic [CW-1:0]  fill_d;
	logic [CW-1:0]  gone_d, wr_i_d, rd_i_d;
	logic           hit_inc, ovf_inc;

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		issue_at = rd_i_q;
		finish   = 1'b0;
		ram_we   = 1'b0;
		ram_wa   = wr_i_q[AW-1:0];
		ram_wd   = ram_rd;
		fill_d   = fill_q;
		gone_d   = gone_q;
		wr_i_d   = wr_i_q;
		rd_i_d   = rd_i_q;
		hit_inc  = 1'b0;
		ovf_inc  = 1'b0;
		res      = '0;
		res.entry_total = 7'(fill_q);
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				unique case (mode_t'(req_q.mode))
					MODE_LOOKUP: begin
						if (rd_pend_q && entry_hits(ram_rd, req_q)) begin
							finish = 1'b1;
							hit_inc = 1'b1;
							res.matched = 1'b1;
							res.result_action = ram_rd.act;
							res.result_packet_rate = ram_rd.pkt;
							res.result_byte_rate = ram_rd.byt;
						end else if (rd_i_q >= fill_q) begin
							finish = !rd_pend_q || 1'b1;
						end else begin
							issue = 1'b1;
							rd_i_d = rd_i_q + 1'b1;
						end
					end
					MODE_APPEND, MODE_INSERT: begin
						if (fill_q == CW'(TABLE_ENTRIES)) begin
							finish = 1'b1;
							ovf_inc = 1'b1;
							res.status = ST_FULL;
						end else if (mode_t'(req_q.mode) == MODE_APPEND) begin
							ram_we = 1'b1;
							ram_wa = fill_q[AW-1:0];
							ram_wd = new_e;
							fill_d = fill_q + 1'b1;
							finish = 1'b1;
							res.insert_position = 7'(fill_q);
							res.entry_total = 7'(fill_q + 1'b1);
						end else if (rd_pend_q && (req_q.entry_priority > ram_rd.prio)) begin
							// found position rd_at_q: shift tail up from the end
							wr_i_d = fill_q;
							state_d = (rd_at_q == fill_q) ? FSM_WRITE : FSM_SHIFT;
							rd_i_d = rd_at_q;   // remembers insert position
						end else if (rd_i_q >= fill_q) begin
							wr_i_d = fill_q;
							rd_i_d = fill_q;
							state_d = FSM_WRITE;
						end else begin
							issue = 1'b1;
							rd_i_d = rd_i_q + 1'b1;
						end
					end
					MODE_REMOVE: begin
						if (idx_ext >= fill_q) begin
							finish = 1'b1;
							res.status = ST_BAD_INDEX;
						end else begin
							// read last entry, move it to the hole
							issue = 1'b1;
							issue_at = fill_q - 1'b1;
							state_d = FSM_MOVE;
						end
					end
					MODE_UPDATE: begin
						if (idx_ext >= fill_q) begin
							finish = 1'b1;
							res.status = ST_BAD_INDEX;
						end else if (!rd_pend_q) begin
							issue = 1'b1;
							issue_at = idx_ext;
						end else begin
							ram_we = 1'b1;
							ram_wa = req_q.entry_index[AW-1:0];
							ram_wd = ram_rd;
							ram_wd.pkt = req_q.packet_rate;
							ram_wd.byt = req_q.byte_rate;
							finish = 1'b1;
						end
					end
					MODE_CLEAR: begin
						fill_d = '0;
						finish = 1'b1;
						res.entry_total = '0;
					end
					MODE_PURGE: begin
						if (rd_pend_q) begin
							if (entry_expired(ram_rd, req_q.current_time)) begin
								gone_d = gone_q + 1'b1;
							end else begin
								ram_we = 1'b1;
								ram_wa = wr_i_q[AW-1:0];
								ram_wd = ram_rd;
								wr_i_d = wr_i_q + 1'b1;
							end
						end
						if (rd_i_q >= fill_q) begin
							if (!rd_pend_q || 1'b1) begin
								finish = 1'b1;
								fill_d = wr_i_d;
								res.purged_now = 7'(gone_d);
								res.entry_total = 7'(wr_i_d);
							end
						end else begin
							issue = 1'b1;
							rd_i_d = rd_i_q + 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			FSM_SHIFT: begin
				// wr_i_q is destination; read wr_i_q-1 then write it
				if (!rd_pend_q) begin
					issue = 1'b1;
					issue_at = wr_i_q - 1'b1;
				end else begin
					ram_we = 1'b1;
					ram_wa = wr_i_q[AW-1:0];
					ram_wd = ram_rd;
					wr_i_d = wr_i_q - 1'b1;
					if (wr_i_d == rd_i_q) begin
						state_d = FSM_WRITE;
					end
				end
			end
			FSM_WRITE: begin
				ram_we = 1'b1;
				ram_wa = rd_i_q[AW-1:0];
				ram_wd = new_e;
				fill_d = fill_q + 1'b1;
				finish = 1'b1;
				res.insert_position = 7'(rd_i_q);
				res.entry_total = 7'(fill_q + 1'b1);
			end
			FSM_MOVE: begin
				if (rd_pend_q) begin
					if (idx_ext != fill_q - 1'b1) begin
						ram_we = 1'b1;
						ram_wa = req_q.entry_index[AW-1:0];
						ram_wd = ram_rd;
					end
					fill_d = fill_q - 1'b1;
					finish = 1'b1;
					res.entry_total = 7'(fill_q - 1'b1);
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
		if (finish) begin
			state_d = FSM_IDLE;
			issue = 1'b0;
		end
		res.hit_total      = hit_q + 64'(hit_inc);
		res.overflow_total = ovf_q + 64'(ovf_inc);
		res.purged_total   = purge_q + 64'(gone_d & {CW{finish}} & {CW{req_q.mode == MODE_PURGE}});
		ram_ra = issue_at[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			fill_q      <= '0;
			rd_i_q      <= '0;
			wr_i_q      <= '0;
			gone_q      <= '0;
			rd_pend_q   <= 1'b0;
			rd_at_q     <= '0;
			hit_q       <= '0;
			ovf_q       <= '0;
			purge_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= issue;
			rd_at_q   <= issue_at;
			if (accept) begin
				rd_i_q <= '0;
				wr_i_q <= '0;
				gone_q <= '0;
			end else begin
				rd_i_q <= rd_i_d;
				wr_i_q <= wr_i_d;
				gone_q <= gone_d;
			end
			if (finish) begin
				fill_q      <= fill_d;
				hit_q       <= res.hit_total;
				ovf_q       <= res.overflow_total;
				purge_q     <= res.purged_total;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (finish) begin
			out_q <= res;
		end
	end

	// checks
	`WPCT_ASSERT_IMP(a_fill_range, clk, arst_n, 1'b1, fill_q <= CW'(TABLE_ENTRIES))
	`WPCT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != FSM_IDLE, !in_ready)
	`WPCT_ASSERT_NXT(a_finish_valid, clk, arst_n, finish, out_valid)
	`WPCT_ASSERT_IMP(a_match_lookup, clk, arst_n, out_valid && out_data.matched,
		req_q.mode == MODE_LOOKUP)
endmodule
`default_nettype wire
